// ===== sv/sam_pkg.sv =====
`default_nettype none
package sam_pkg;

    localparam int DEF_MAX_LEN  = 1024;
    localparam int DEF_ALPHABET = 26;

    localparam logic [1:0] FN_APPEND = 2'd0;
    localparam logic [1:0] FN_QUERY  = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;
    localparam logic [1:0] FN_RSVD   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_NOTFIN = 2'd2;
    localparam logic [1:0] ST_OVF    = 2'd3;

endpackage
`default_nettype wire

// ===== sv/suffix_automaton_max_occurrence_core.sv =====
`default_nettype none
// channel | dir | tdata (low bit up)                        | tuser  | tlast
// s_*     | in  | symbol[4:0], query_length[15:5]            | func   | final_symbol
// m_*     | out | max_occurrences[10:0], status[12:11], 0s   | -      | -
//
// One item at a time. A query with an error status answers straight from idle;
// a valid query first reads the best table. Append makes the new state, then
// walks the suffix links; an existing edge adds a length check, a clone two link
// writes and a redirect walk along the suffix links. Finalize sorts the states
// by length, sums counts up the suffix links and builds the best table.
// After reset or clear, the init state writes the root entry before input is taken.
// A waiting result blocks new input until the m side takes it.
module suffix_automaton_max_occurrence_core
    import sam_pkg::*;
#(
    parameter int MAX_LEN  = DEF_MAX_LEN,
    parameter int ALPHABET = DEF_ALPHABET
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // symbol[4:0], query_length[15:5]
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    input  wire logic        s_tlast,   // final_symbol
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // max_occurrences[10:0], status[12:11]
);

    localparam int NST = 2 * MAX_LEN + 2;
    localparam int NB  = MAX_LEN + 2;
    localparam int SW  = $clog2(NST);
    localparam int LW  = $clog2(NB);
    localparam int AW  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int RW  = ALPHABET * SW;

    typedef enum logic [18:0] {
        S_INIT    = 19'd1 << 0,
        S_IDLE    = 19'd1 << 1,
        S_AP1     = 19'd1 << 2,
        S_WALK    = 19'd1 << 3,
        S_QCHK    = 19'd1 << 4,
        S_CL1     = 19'd1 << 5,
        S_CL2     = 19'd1 << 6,
        S_CWALK   = 19'd1 << 7,
        S_APEND   = 19'd1 << 8,
        S_CLRB    = 19'd1 << 9,
        S_CNT     = 19'd1 << 10,
        S_PREF    = 19'd1 << 11,
        S_SORT    = 19'd1 << 12,
        S_ACC     = 19'd1 << 13,
        S_CLRBEST = 19'd1 << 14,
        S_BEST    = 19'd1 << 15,
        S_SUFF    = 19'd1 << 16,
        S_QRY     = 19'd1 << 17,
        S_SPARE   = 19'd1 << 18
    } state_t;

    // memories
    logic [RW-1:0] tr_mem [NST];
    logic [SW-1:0] lk_mem [NST];
    logic [LW-1:0] ln_mem [NST];
    logic [LW-1:0] ct_mem [NST];
    logic [SW-1:0] bk_mem [NB];
    logic [SW-1:0] od_mem [NST];
    logic [LW-1:0] bs_mem [NB];

    logic [SW-1:0] tr_ra, tr_wa, lk_ra, lk_wa, ln_ra, ln_wa, ct_ra, ct_wa, od_ra, od_wa;
    logic [LW-1:0] bk_ra, bk_wa, bs_ra, bs_wa;
    logic          tr_we, lk_we, ln_we, ct_we, bk_we, od_we, bs_we;
    logic [RW-1:0] tr_wd, tr_rd;
    logic [SW-1:0] lk_wd, lk_rd, bk_wd, bk_rd, od_wd, od_rd;
    logic [LW-1:0] ln_wd, ln_rd, ct_wd, ct_rd, bs_wd, bs_rd;

    always_ff @(posedge clk)
    begin
        if (tr_we)
            tr_mem[tr_wa] <= tr_wd;
        tr_rd <= tr_mem[tr_ra];
        if (lk_we)
            lk_mem[lk_wa] <= lk_wd;
        lk_rd <= lk_mem[lk_ra];
        if (ln_we)
            ln_mem[ln_wa] <= ln_wd;
        ln_rd <= ln_mem[ln_ra];
        if (ct_we)
            ct_mem[ct_wa] <= ct_wd;
        ct_rd <= ct_mem[ct_ra];
        if (bk_we)
            bk_mem[bk_wa] <= bk_wd;
        bk_rd <= bk_mem[bk_ra];
        if (od_we)
            od_mem[od_wa] <= od_wd;
        od_rd <= od_mem[od_ra];
        if (bs_we)
            bs_mem[bs_wa] <= bs_wd;
        bs_rd <= bs_mem[bs_ra];
    end

    state_t        state_reg, state_next;
    logic [SW-1:0] sc_reg, sc_next, last_reg, last_next;
    logic [LW-1:0] slen_reg, slen_next;
    logic          fin_reg, fin_next, ovf_reg, ovf_next, fl_reg, fl_next;
    logic [SW-1:0] x_reg, x_next, p_reg, p_next, q_reg, q_next, c_reg, c_next;
    logic [AW-1:0] w_reg, w_next;
    logic [LW-1:0] lenx_reg, lenx_next, tmp_reg, tmp_next, vcnt_reg, vcnt_next;
    logic [SW-1:0] idx_reg, idx_next, acc_reg, acc_next;
    logic [1:0]    ph_reg, ph_next;
    logic          ov_reg, ov_next;
    logic [10:0]   occ_reg, occ_next;
    logic [1:0]    st_reg, st_next;

    logic [1:0]    func;
    logic [4:0]    sym;
    logic [10:0]   qlen;
    logic          acc_in;
    logic [SW-1:0] edge_val, n_ext, sum;
    logic [RW-1:0] row_mod;
    logic [LW-1:0] run_max;

    assign func     = s_tuser;
    assign sym      = s_tdata[4:0];
    assign qlen     = s_tdata[15:5];
    assign s_tready = (state_reg == S_IDLE) && !ov_reg;
    assign acc_in   = s_tvalid && s_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {3'b000, st_reg, occ_reg};
    assign edge_val = tr_rd[w_reg*SW +: SW];
    assign n_ext    = SW'(slen_reg);

    always_comb
    begin
        state_next = state_reg;
        sc_next    = sc_reg;
        last_next  = last_reg;
        slen_next  = slen_reg;
        fin_next   = fin_reg;
        ovf_next   = ovf_reg;
        fl_next    = fl_reg;
        x_next     = x_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        c_next     = c_reg;
        w_next     = w_reg;
        lenx_next  = lenx_reg;
        tmp_next   = tmp_reg;
        vcnt_next  = vcnt_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        ph_next    = ph_reg;
        ov_next    = ov_reg;
        occ_next   = occ_reg;
        st_next    = st_reg;
        row_mod    = tr_rd;
        sum        = '0;
        run_max    = '0;

        tr_ra = x_reg;  lk_ra = x_reg;  ln_ra = x_reg;  ct_ra = x_reg;
        od_ra = idx_reg; bk_ra = LW'(idx_reg); bs_ra = LW'(idx_reg);
        tr_we = 1'b0; lk_we = 1'b0; ln_we = 1'b0; ct_we = 1'b0;
        bk_we = 1'b0; od_we = 1'b0; bs_we = 1'b0;
        tr_wa = x_reg; lk_wa = p_reg; ln_wa = p_reg; ct_wa = p_reg;
        od_wa = idx_reg; bk_wa = LW'(idx_reg); bs_wa = LW'(idx_reg);
        tr_wd = '0; lk_wd = '0; ln_wd = '0; ct_wd = '0;
        bk_wd = '0; od_wd = '0; bs_wd = '0;

        if (ov_reg && m_tready)
            ov_next = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                tr_we = 1'b1; tr_wa = SW'(1);
                lk_we = 1'b1; lk_wa = SW'(1);
                ln_we = 1'b1; ln_wa = SW'(1);
                ct_we = 1'b1; ct_wa = SW'(1);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (acc_in)
                begin
                    case (func)
                        FN_APPEND:
                        begin
                            if (!fin_reg)
                            begin
                                fl_next = s_tlast;
                                idx_next = '0;
                                if (32'(slen_reg) >= MAX_LEN)
                                begin
                                    ovf_next = 1'b1;
                                    if (s_tlast)
                                        state_next = S_CLRB;
                                end
                                else if (32'(sym) < ALPHABET)
                                begin
                                    w_next = AW'(sym);
                                    ln_ra = last_reg;
                                    state_next = S_AP1;
                                end
                                else if (s_tlast)
                                    state_next = S_CLRB;
                            end
                        end
                        FN_QUERY:
                        begin
                            occ_next = '0;
                            if (ovf_reg)
                            begin
                                st_next = ST_OVF; ov_next = 1'b1;
                            end
                            else if (!fin_reg)
                            begin
                                st_next = ST_NOTFIN; ov_next = 1'b1;
                            end
                            else if (qlen == '0 || 32'(qlen) > 32'(slen_reg))
                            begin
                                st_next = ST_RANGE; ov_next = 1'b1;
                            end
                            else
                            begin
                                bs_ra = LW'(qlen);
                                state_next = S_QRY;
                            end
                        end
                        FN_CLEAR:
                        begin
                            sc_next = SW'(1); last_next = SW'(1);
                            slen_next = '0; fin_next = 1'b0; ovf_next = 1'b0;
                            state_next = S_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_QRY:
            begin
                occ_next = 11'(bs_rd);
                st_next = ST_OK;
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            S_AP1:
            begin
                p_next = sc_reg + 1'b1;
                ln_we = 1'b1; ln_wa = p_next; ln_wd = ln_rd + 1'b1;
                ct_we = 1'b1; ct_wa = p_next; ct_wd = LW'(1);
                tr_we = 1'b1; tr_wa = p_next; tr_wd = '0;
                sc_next = p_next; last_next = p_next;
                slen_next = slen_reg + 1'b1;
                x_next = last_reg;
                tr_ra = last_reg; lk_ra = last_reg; ln_ra = last_reg;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (edge_val == '0)
                begin
                    row_mod[w_reg*SW +: SW] = p_reg;
                    tr_we = 1'b1; tr_wa = x_reg; tr_wd = row_mod;
                    if (lk_rd == '0)
                    begin
                        lk_we = 1'b1; lk_wa = p_reg; lk_wd = SW'(1);
                        state_next = S_APEND;
                    end
                    else
                    begin
                        x_next = lk_rd;
                        tr_ra = lk_rd; lk_ra = lk_rd; ln_ra = lk_rd;
                    end
                end
                else
                begin
                    q_next = edge_val;
                    lenx_next = ln_rd;
                    tr_ra = edge_val; lk_ra = edge_val; ln_ra = edge_val;
                    state_next = S_QCHK;
                end
            end
            S_QCHK:
            begin
                if (lenx_reg + 1'b1 == ln_rd)
                begin
                    lk_we = 1'b1; lk_wa = p_reg; lk_wd = q_reg;
                    state_next = S_APEND;
                end
                else
                begin
                    c_next = sc_reg + 1'b1;
                    sc_next = c_next;
                    tr_we = 1'b1; tr_wa = c_next; tr_wd = tr_rd;
                    lk_we = 1'b1; lk_wa = c_next; lk_wd = lk_rd;
                    ln_we = 1'b1; ln_wa = c_next; ln_wd = lenx_reg + 1'b1;
                    ct_we = 1'b1; ct_wa = c_next; ct_wd = '0;
                    state_next = S_CL1;
                end
            end
            S_CL1:
            begin
                lk_we = 1'b1; lk_wa = p_reg; lk_wd = c_reg;
                state_next = S_CL2;
            end
            S_CL2:
            begin
                lk_we = 1'b1; lk_wa = q_reg; lk_wd = c_reg;
                state_next = S_CWALK;
            end
            S_CWALK:
            begin
                if (edge_val == q_reg)
                begin
                    row_mod[w_reg*SW +: SW] = c_reg;
                    tr_we = 1'b1; tr_wa = x_reg; tr_wd = row_mod;
                    if (lk_rd == '0)
                        state_next = S_APEND;
                    else
                    begin
                        x_next = lk_rd;
                        tr_ra = lk_rd; lk_ra = lk_rd;
                    end
                end
                else
                    state_next = S_APEND;
            end
            S_APEND:
            begin
                idx_next = '0;
                state_next = fl_reg ? S_CLRB : S_IDLE;
            end
            S_CLRB:
            begin
                bk_we = 1'b1; bk_wd = '0;
                ph_next = '0;
                if (idx_reg == n_ext)
                begin
                    idx_next = SW'(1);
                    state_next = S_CNT;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_CNT:
            begin
                case (ph_reg)
                    2'd0:
                    begin
                        ln_ra = idx_reg; ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        bk_ra = ln_rd; tmp_next = ln_rd; ph_next = 2'd2;
                    end
                    default:
                    begin
                        bk_we = 1'b1; bk_wa = tmp_reg; bk_wd = bk_rd + 1'b1;
                        ph_next = 2'd0;
                        if (idx_reg == sc_reg)
                        begin
                            idx_next = '0; acc_next = '0; state_next = S_PREF;
                        end
                        else
                            idx_next = idx_reg + 1'b1;
                    end
                endcase
            end
            S_PREF:
            begin
                if (ph_reg == 2'd0)
                    ph_next = 2'd1;
                else
                begin
                    sum = acc_reg + bk_rd;
                    bk_we = 1'b1; bk_wd = sum;
                    acc_next = sum;
                    ph_next = 2'd0;
                    if (idx_reg == n_ext)
                    begin
                        idx_next = SW'(1); state_next = S_SORT;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            S_SORT:
            begin
                case (ph_reg)
                    2'd0:
                    begin
                        ln_ra = idx_reg; ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        bk_ra = ln_rd; tmp_next = ln_rd; ph_next = 2'd2;
                    end
                    default:
                    begin
                        od_we = 1'b1; od_wa = bk_rd; od_wd = idx_reg;
                        bk_we = 1'b1; bk_wa = tmp_reg; bk_wd = bk_rd - 1'b1;
                        ph_next = 2'd0;
                        if (idx_reg == sc_reg)
                            state_next = S_ACC;
                        else
                            idx_next = idx_reg + 1'b1;
                    end
                endcase
            end
            S_ACC:
            begin
                case (ph_reg)
                    2'd0:
                    begin
                        ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        lk_ra = od_rd; ct_ra = od_rd; ph_next = 2'd2;
                    end
                    default:
                    begin
                        if (ph_reg == 2'd2 && lk_rd != '0)
                        begin
                            x_next = lk_rd; vcnt_next = ct_rd;
                            ct_ra = lk_rd; ph_next = 2'd3;
                        end
                        else
                        begin
                            if (ph_reg == 2'd3)
                            begin
                                ct_we = 1'b1; ct_wa = x_reg; ct_wd = ct_rd + vcnt_reg;
                            end
                            ph_next = 2'd0;
                            if (idx_reg == SW'(1))
                            begin
                                idx_next = '0; state_next = S_CLRBEST;
                            end
                            else
                                idx_next = idx_reg - 1'b1;
                        end
                    end
                endcase
            end
            S_CLRBEST:
            begin
                bs_we = 1'b1; bs_wd = '0;
                if (idx_reg == n_ext + 1'b1)
                begin
                    idx_next = SW'(1); state_next = S_BEST;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_BEST:
            begin
                case (ph_reg)
                    2'd0:
                    begin
                        ln_ra = idx_reg; ct_ra = idx_reg; ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        bs_ra = ln_rd; tmp_next = ln_rd; vcnt_next = ct_rd;
                        ph_next = 2'd2;
                    end
                    default:
                    begin
                        if (vcnt_reg > bs_rd)
                        begin
                            bs_we = 1'b1; bs_wa = tmp_reg; bs_wd = vcnt_reg;
                        end
                        ph_next = 2'd0;
                        vcnt_next = '0;
                        if (idx_reg == sc_reg)
                        begin
                            idx_next = n_ext;
                            if (slen_reg == '0)
                            begin
                                fin_next = 1'b1; state_next = S_IDLE;
                            end
                            else
                                state_next = S_SUFF;
                        end
                        else
                            idx_next = idx_reg + 1'b1;
                    end
                endcase
            end
            S_SUFF:
            begin
                if (ph_reg == 2'd0)
                    ph_next = 2'd1;
                else
                begin
                    run_max = (bs_rd > vcnt_reg) ? bs_rd : vcnt_reg;
                    bs_we = 1'b1; bs_wd = run_max;
                    vcnt_next = run_max;
                    ph_next = 2'd0;
                    if (idx_reg == SW'(1))
                    begin
                        fin_next = 1'b1; state_next = S_IDLE;
                    end
                    else
                        idx_next = idx_reg - 1'b1;
                end
            end
            default:
                state_next = S_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            sc_reg    <= SW'(1);
            last_reg  <= SW'(1);
            slen_reg  <= '0;
            fin_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            ph_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sc_reg    <= sc_next;
            last_reg  <= last_next;
            slen_reg  <= slen_next;
            fin_reg   <= fin_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
            ph_reg    <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fl_reg   <= fl_next;
        x_reg    <= x_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        c_reg    <= c_next;
        w_reg    <= w_next;
        lenx_reg <= lenx_next;
        tmp_reg  <= tmp_next;
        vcnt_reg <= vcnt_next;
        idx_reg  <= idx_next;
        acc_reg  <= acc_next;
        occ_reg  <= occ_next;
        st_reg   <= st_next;
    end

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
module tb;
    import sam_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXL = DEF_MAX_LEN;
    localparam int ALPH = DEF_ALPHABET;
    localparam int NST = 2 * MAXL + 2;
    localparam int WDOG_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] occ;
    } occ_result_t;

    class occ_scoreboard;
        int trans [NST][ALPH];
        int link [NST];
        int maxlen [NST];
        int cnt [NST];
        int order [NST];
        int bucket [MAXL + 1];
        int best [MAXL + 2];
        int nstates, tail, slen;
        bit done_str, ovf;
        occ_result_t pending[$];
        int errors;

        function void clear_all();
            foreach (trans[i, j]) trans[i][j] = 0;
            foreach (link[i])
            begin
                link[i] = 0;
                maxlen[i] = 0;
                cnt[i] = 0;
                order[i] = 0;
            end
            foreach (bucket[i]) bucket[i] = 0;
            foreach (best[i]) best[i] = 0;
            nstates = 1;
            tail = 1;
            slen = 0;
            done_str = 0;
            ovf = 0;
        endfunction

        function void extend(int w);
            int x, p, q, c;
            x = tail;
            nstates++;
            p = nstates;
            maxlen[p] = maxlen[x] + 1;
            cnt[p] = 1;
            tail = p;
            while (x != 0 && trans[x][w] == 0)
            begin
                trans[x][w] = p;
                x = link[x];
            end
            if (x == 0)
                link[p] = 1;
            else
            begin
                q = trans[x][w];
                if (maxlen[x] + 1 == maxlen[q])
                    link[p] = q;
                else
                begin
                    nstates++;
                    c = nstates;
                    for (int k = 0; k < ALPH; k++) trans[c][k] = trans[q][k];
                    link[c] = link[q];
                    maxlen[c] = maxlen[x] + 1;
                    cnt[c] = 0;
                    link[p] = c;
                    link[q] = c;
                    while (x != 0 && trans[x][w] == q)
                    begin
                        trans[x][w] = c;
                        x = link[x];
                    end
                end
            end
            slen++;
        endfunction

        function void finish();
            int v, up, len;
            foreach (bucket[i]) bucket[i] = 0;
            for (int i = 1; i <= nstates; i++) bucket[maxlen[i]]++;
            for (int i = 1; i <= slen; i++) bucket[i] += bucket[i - 1];
            for (int i = 1; i <= nstates; i++)
            begin
                len = maxlen[i];
                order[bucket[len]] = i;
                bucket[len]--;
            end
            for (int i = nstates; i >= 1; i--)
            begin
                v = order[i];
                up = link[v];
                if (up != 0) cnt[up] += cnt[v];
            end
            foreach (best[i]) best[i] = 0;
            for (int i = 1; i <= nstates; i++)
                if (cnt[i] > best[maxlen[i]]) best[maxlen[i]] = cnt[i];
            for (int i = slen; i >= 1; i--)
                if (best[i + 1] > best[i]) best[i] = best[i + 1];
            done_str = 1;
        endfunction

        function void note_input(logic [1:0] fn, logic [4:0] sym, logic fin,
                                 logic [10:0] qlen);
            occ_result_t r;
            if (fn == FN_APPEND)
            begin
                if (done_str) return;
                if (slen >= MAXL) ovf = 1;
                else if (sym < ALPH) extend(sym);
                if (fin) finish();
            end
            else if (fn == FN_QUERY)
            begin
                r.occ = '0;
                if (ovf) r.status = ST_OVF;
                else if (!done_str) r.status = ST_NOTFIN;
                else if (qlen < 1 || qlen > slen) r.status = ST_RANGE;
                else
                begin
                    r.status = ST_OK;
                    r.occ = 11'(best[qlen]);
                end
                pending.push_back(r);
            end
            else if (fn == FN_CLEAR)
                clear_all();
        endfunction

        function void check_result(logic [15:0] d);
            occ_result_t e;
            if (pending.size() == 0)
            begin
                report("unexpected result", d);
                return;
            end
            e = pending.pop_front();
            if (d[12:11] !== e.status) report("status mismatch", d);
            if (d[10:0] !== e.occ) report("count mismatch", d);
        endfunction

        function void report(string what, logic [15:0] d);
            errors++;
            $display("tb: %s: got %h at %0t", what, d, $realtime);
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [15:0] s_tdata = 0;
    logic [1:0] s_tuser = 0;
    logic s_tlast = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [15:0] m_tdata;

    occ_scoreboard sb;
    bit hold_off = 0;
    bit stim_done = 0;
    int idle_cycles = 0;

    always #4 clk = ~clk;

    suffix_automaton_max_occurrence_core u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // burst/gap state for the sender
    int burst_left = 0;

    // a new burst always starts after a gap, so that
    // valid is dropped and raised in different time steps
    task automatic send_item(logic [1:0] fn, logic [4:0] sym, logic fin,
                             logic [10:0] qlen);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        s_tvalid <= 1;
        s_tuser <= fn;
        s_tdata <= {qlen, sym};
        s_tlast <= fin;
        do @(posedge clk); while (!s_tready);
        sb.note_input(fn, sym, fin, qlen);
        if (burst_left == 0) s_tvalid <= 0;
    endtask

    task automatic append_str(int n, int alph, bit fin);
        for (int i = 0; i < n; i++)
            send_item(FN_APPEND, 5'($urandom_range(0, alph - 1)), fin && i == n - 1,
                      11'($urandom));
    endtask

    task automatic query_rand(int n);
        send_item(FN_QUERY, 5'($urandom), 1'($urandom), 11'($urandom_range(0, n + 2)));
    endtask

    // receiver
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (hold_off) m_tready <= 0;
        else m_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n || hold_off)
            idle_cycles <= 0;
        else if (!stim_done || sb.pending.size() != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    int nitems;
    int n;

    initial
    begin
        sb = new();
        sb.clear_all();
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: queries before finalize, illegal ops, extremes
        send_item(FN_QUERY, 5'd0, 1'b0, 11'd1);
        send_item(FN_RSVD, 5'd31, 1'b1, 11'h7ff);
        send_item(FN_APPEND, 5'd0, 1'b0, 11'd0);
        send_item(FN_APPEND, 5'd25, 1'b0, 11'h7ff);
        send_item(FN_APPEND, 5'd26, 1'b0, 11'd0);
        send_item(FN_APPEND, 5'd31, 1'b0, 11'd0);
        send_item(FN_APPEND, 5'd0, 1'b0, 11'd0);
        send_item(FN_APPEND, 5'd0, 1'b1, 11'd0);
        send_item(FN_APPEND, 5'd1, 1'b1, 11'd0);
        send_item(FN_QUERY, 5'd0, 1'b0, 11'd0);
        send_item(FN_QUERY, 5'd0, 1'b0, 11'd1);
        send_item(FN_QUERY, 5'd0, 1'b0, 11'd2);
        send_item(FN_QUERY, 5'd0, 1'b0, 11'd4);
        send_item(FN_QUERY, 5'd0, 1'b0, 11'd5);
        send_item(FN_QUERY, 5'd0, 1'b0, 11'h7ff);
        send_item(FN_CLEAR, 5'd0, 1'b0, 11'd0);
        // empty string finalized via dropped symbol
        send_item(FN_APPEND, 5'd30, 1'b1, 11'd0);
        send_item(FN_QUERY, 5'd0, 1'b0, 11'd1);
        send_item(FN_CLEAR, 5'd0, 1'b0, 11'd0);

        // long receiver hold-off while queries keep coming
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            begin
                append_str(6, 2, 1);
                for (int i = 0; i < 8; i++) query_rand(6);
            end
        join
        send_item(FN_CLEAR, 5'd0, 1'b0, 11'd0);

        nitems = 0;
        while (nitems < 660)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                            : $urandom_range(1, 16);
            append_str(n, $urandom_range(1, 4) == 1 ? ALPH : $urandom_range(2, 4),
                       $urandom_range(0, 7) != 0);
            nitems += n;
            for (int i = $urandom_range(2, 10); i > 0; i--)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(2'($urandom), 5'($urandom), 1'($urandom), 11'($urandom));
                else
                    query_rand(n);
                nitems++;
            end
            send_item(FN_CLEAR, 5'($urandom), 1'($urandom), 11'($urandom));
            nitems++;
        end
        if (burst_left != 0) s_tvalid <= 0;
        stim_done = 1;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
